[rtl/core/sfr_pkg.sv]
// Package for the stream find-and-replace core: payload structs, configuration
// register indexes and default sizes. Every module of the core imports it.
// No dependencies.
package sfr_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPL_MAX_DEF    = 8;

    localparam int CFG_DW = 64;
    localparam int CFG_IW = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IW-1:0] {
        REG_PATTERN_BYTES = 3'd0,
        REG_PATTERN_LEN   = 3'd1,
        REG_REPL_BYTES    = 3'd2,
        REG_REPL_LEN      = 3'd3
    } cfg_reg_t;

    // One text byte entering the core.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } text_in_t;

    // One result leaving the core.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } result_t;

endpackage

[rtl/core/sfr_match.sv]
// Combinational step of the find-and-replace core: appends a byte to the window,
// compares it with the pattern and builds the results of that byte.
// Depends on sfr_pkg.
module sfr_match #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
    parameter int REPL_MAX    = sfr_pkg::REPL_MAX_DEF,
    parameter int RES_MAX     = (PATTERN_MAX > REPL_MAX) ? PATTERN_MAX : REPL_MAX,
    parameter int FW          = $clog2(PATTERN_MAX + 1),
    parameter int RW          = $clog2(REPL_MAX + 1),
    parameter int CW          = $clog2(RES_MAX + 1)
) (
    input  sfr_pkg::text_in_t                  item,
    input  logic [PATTERN_MAX-1:0][7:0]        win,
    input  logic [FW-1:0]                      fill,
    input  logic [PATTERN_MAX*8-1:0]           pat_bytes,
    input  logic [FW-1:0]                      plen,
    input  logic [REPL_MAX*8-1:0]              repl_bytes,
    input  logic [RW-1:0]                      rlen,
    output logic [PATTERN_MAX-1:0][7:0]        win_next,
    output logic [FW-1:0]                      fill_next,
    output sfr_pkg::result_t [RES_MAX-1:0]     res,
    output logic [CW-1:0]                      res_count
);
    import sfr_pkg::*;

    logic [FW-1:0]               fill0;
    logic [FW-1:0]               fill1;
    logic [PATTERN_MAX-1:0][7:0] w;
    logic                        full;
    logic                        hit;

    always_comb
    begin
        fill0 = (fill >= plen) ? '0 : fill;
        fill1 = fill0 + FW'(1);

        w = win;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (FW'(k) == fill0)
            begin
                w[k] = item.text_byte;
            end
        end

        full = (fill1 == plen);
        hit  = full;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if ((FW'(k) < plen) && (w[k] != pat_bytes[8*k +: 8]))
            begin
                hit = 1'b0;
            end
        end

        res       = '0;
        res_count = '0;
        if (hit)
        begin
            for (int k = 0; k < REPL_MAX; k++)
            begin
                res[k].out_byte  = repl_bytes[8*k +: 8];
                res[k].out_valid = 1'b1;
            end
            res_count = CW'(rlen);
            // A deleted match at the end of the text still needs an end marker.
            if (item.text_last && (rlen == '0))
            begin
                res[0]    = '0;
                res_count = CW'(1);
            end
        end
        else if (item.text_last)
        begin
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                res[k].out_byte  = w[k];
                res[k].out_valid = 1'b1;
            end
            res_count = CW'(fill1);
        end
        else if (full)
        begin
            res[0].out_byte  = w[0];
            res[0].out_valid = 1'b1;
            res_count        = CW'(1);
        end

        if (item.text_last)
        begin
            for (int k = 0; k < RES_MAX; k++)
            begin
                if (CW'(k + 1) == res_count)
                begin
                    res[k].out_last = 1'b1;
                end
            end
        end

        win_next  = w;
        fill_next = fill1;
        if (hit || item.text_last)
        begin
            fill_next = '0;
        end
        else if (full)
        begin
            for (int k = 0; k < PATTERN_MAX - 1; k++)
            begin
                win_next[k] = w[k + 1];
            end
            win_next[PATTERN_MAX-1] = 8'd0;
            fill_next               = fill1 - FW'(1);
        end
    end

endmodule

[rtl/core/sfr_resq.sv]
// Result queue of the find-and-replace core: holds the results of one text
// byte and hands them out one per cycle while result_stall is low. Depends on sfr_pkg.
module sfr_resq #(
    parameter int RES_MAX = sfr_pkg::PATTERN_MAX_DEF,
    parameter int CW      = $clog2(RES_MAX + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  sfr_pkg::result_t [RES_MAX-1:0] load_res,
    input  logic [CW-1:0]                  load_count,
    output logic                           can_load,
    output sfr_pkg::result_t               result,
    output logic                           result_valid,
    input  logic                           result_stall
);
    import sfr_pkg::*;

    result_t [RES_MAX-1:0] q_reg;
    result_t [RES_MAX-1:0] q_next;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic                  pop;

    assign pop          = (cnt_reg != '0) && !result_stall;
    // The queue can take new results once the last one held leaves this cycle.
    assign can_load     = (cnt_reg == '0) || ((cnt_reg == CW'(1)) && !result_stall);
    assign result       = q_reg[0];
    assign result_valid = (cnt_reg != '0);

    always_comb
    begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            q_next   = load_res;
            cnt_next = load_count;
        end
        else if (pop)
        begin
            for (int k = 0; k < RES_MAX - 1; k++)
            begin
                q_next[k] = q_reg[k + 1];
            end
            q_next[RES_MAX-1] = '0;
            cnt_next          = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

[rtl/core/stream_find_replace_core.sv]
// Stream find-and-replace core: replaces every leftmost, non-overlapping match.
// The first result of a text byte is registered and offered in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and result_stall
// is low; a byte that yields several results holds the input while the result queue drains.
// Reset (rst_n, asynchronous, active low) restores the register defaults, empties the
// window and the result queue. Depends on sfr_pkg, sfr_match and sfr_resq.
module stream_find_replace_core #(
    parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
    parameter int REPL_MAX    = sfr_pkg::REPL_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sfr_pkg::CFG_IW-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_DW-1:0] cfg_data,
    input  sfr_pkg::text_in_t          text,
    input  logic                       text_valid,
    output logic                       text_stall,
    output sfr_pkg::result_t           result,
    output logic                       result_valid,
    input  logic                       result_stall
);
    import sfr_pkg::*;

    // The result queue must hold the largest burst of one byte: a full
    // replacement, or a whole window flushed at the end of the text.
    localparam int RES_MAX = (PATTERN_MAX > REPL_MAX) ? PATTERN_MAX : REPL_MAX;
    localparam int FW      = $clog2(PATTERN_MAX + 1);
    localparam int RW      = $clog2(REPL_MAX + 1);
    localparam int CW      = $clog2(RES_MAX + 1);

    // Configuration registers. Only the bytes that the sizes can use are kept.
    logic [PATTERN_MAX*8-1:0] pattern_bytes_reg;
    logic [3:0]               pattern_len_reg;
    logic [REPL_MAX*8-1:0]    repl_bytes_reg;
    logic [3:0]               repl_len_reg;

    // The window holds the text bytes that are not yet resolved, oldest first.
    logic [PATTERN_MAX-1:0][7:0] win_reg;
    logic [PATTERN_MAX-1:0][7:0] win_next;
    logic [FW-1:0]               fill_reg;
    logic [FW-1:0]               fill_next;

    logic [FW-1:0]               plen;
    logic [RW-1:0]               rlen;
    result_t [RES_MAX-1:0]       step_res;
    logic [CW-1:0]               step_count;
    logic                        can_load;
    logic                        text_accept;

    // A transaction on the text channel is taken only when the result queue
    // is free for its results at the same edge.
    assign text_stall  = !can_load;
    assign text_accept = text_valid && can_load;

    // Length registers are clamped into the range the hardware supports; a
    // pattern length of zero behaves as one.
    always_comb
    begin
        if (pattern_len_reg == 4'd0)
        begin
            plen = FW'(1);
        end
        else if (pattern_len_reg > 4'(PATTERN_MAX))
        begin
            plen = FW'(PATTERN_MAX);
        end
        else
        begin
            plen = FW'(pattern_len_reg);
        end

        if (repl_len_reg > 4'(REPL_MAX))
        begin
            rlen = RW'(REPL_MAX);
        end
        else
        begin
            rlen = RW'(repl_len_reg);
        end
    end

    sfr_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPL_MAX    (REPL_MAX),
        .RES_MAX     (RES_MAX),
        .FW          (FW),
        .RW          (RW),
        .CW          (CW)
    ) u_match (
        .item       (text),
        .win        (win_reg),
        .fill       (fill_reg),
        .pat_bytes  (pattern_bytes_reg),
        .plen       (plen),
        .repl_bytes (repl_bytes_reg),
        .rlen       (rlen),
        .win_next   (win_next),
        .fill_next  (fill_next),
        .res        (step_res),
        .res_count  (step_count)
    );

    sfr_resq #(
        .RES_MAX (RES_MAX),
        .CW      (CW)
    ) u_resq (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (text_accept),
        .load_res     (step_res),
        .load_count   (step_count),
        .can_load     (can_load),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // Configuration writes must arrive only while the core is idle, so that they never
    // meet a text transaction; the core does not enforce this. Writing the pattern length discards the window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg <= '0;
            pattern_len_reg   <= 4'd1;
            repl_bytes_reg    <= '0;
            repl_len_reg      <= 4'd0;
            win_reg           <= '0;
            fill_reg          <= '0;
        end
        else
        begin
            if (text_accept)
            begin
                win_reg  <= win_next;
                fill_reg <= fill_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PATTERN_BYTES:
                    begin
                        pattern_bytes_reg <= cfg_data[PATTERN_MAX*8-1:0];
                    end
                    REG_PATTERN_LEN:
                    begin
                        pattern_len_reg <= cfg_data[3:0];
                        fill_reg        <= '0;
                    end
                    REG_REPL_BYTES:
                    begin
                        repl_bytes_reg <= cfg_data[REPL_MAX*8-1:0];
                    end
                    REG_REPL_LEN:
                    begin
                        repl_len_reg <= cfg_data[3:0];
                    end
                    default:
                    begin
                        // Indexes beyond the register list are ignored.
                    end
                endcase
            end
        end
    end

endmodule
